/* rtl/ddd_pkg.sv */
// ----------------------------------------------------------------------------
// ddd_pkg
// Shared types, constants and calendar helpers for the date difference block.
// ----------------------------------------------------------------------------
package ddd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DIFF_W  = 23;
    localparam int ACC_W   = 25;
    localparam int R400_W  = 9;
    localparam int OFF_W   = 9;

    localparam logic [YEAR_W-1:0]       YEAR_CYCLE = 14'd400;
    localparam logic signed [ACC_W-1:0] DIFF_MAX   = 25'sd4194303;
    localparam logic signed [ACC_W-1:0] LEN_COMMON = 25'sd365;
    localparam logic signed [ACC_W-1:0] LEN_LEAP   = 25'sd366;

    localparam logic [OFF_W-1:0] MONTH_CUM [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [YEAR_W-1:0]  later_year;
        logic [MONTH_W-1:0] later_month;
        logic [DAY_W-1:0]   later_day;
        logic [YEAR_W-1:0]  earlier_year;
        logic [MONTH_W-1:0] earlier_month;
        logic [DAY_W-1:0]   earlier_day;
    } request_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] day_difference;
        logic                     order_error;
    } result_t;

    typedef struct packed {
        logic                    sub;
        logic signed [ACC_W-1:0] a;
        logic signed [ACC_W-1:0] b;
    } alu_op_t;

    // days in the months before month m, months above twelve count as twelve
    function automatic logic [OFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [MONTH_W-1:0] idx;
        logic [OFF_W-1:0]   off;
        idx = (m > 4'd12) ? 4'd11 : (m - 4'd1);
        if (m == 4'd0) begin
            off = '0;
        end else begin
            off = MONTH_CUM[idx];
            if (leap && (m >= 4'd3)) begin
                off = off + 9'd1;
            end
        end
        return off;
    endfunction

    function automatic logic signed [ACC_W-1:0] year_len(input logic leap);
        return leap ? LEN_LEAP : LEN_COMMON;
    endfunction

endpackage

/* rtl/ddd_alu.sv */
// ----------------------------------------------------------------------------
// ddd_alu
// Shared add/subtract unit for accumulation, reduction and compare.
// ----------------------------------------------------------------------------
module ddd_alu (
    input  ddd_pkg::alu_op_t                  op,
    output logic signed [ddd_pkg::ACC_W-1:0]  sum
);

    always_comb
    begin
        if (op.sub)
        begin
            sum = op.a - op.b;
        end
        else
        begin
            sum = op.a + op.b;
        end
    end

endmodule

/* rtl/ddd_leap.sv */
// ----------------------------------------------------------------------------
// ddd_leap
// Leap year test from the year taken modulo 400.
// ----------------------------------------------------------------------------
module ddd_leap (
    input  logic [ddd_pkg::R400_W-1:0] r400,
    output logic                       leap
);

    logic div4;
    logic div100;
    logic div400;

    assign div4   = (r400[1:0] == 2'd0);
    assign div400 = (r400 == 9'd0);
    assign div100 = div400 || (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
    assign leap   = (div4 && !div100) || div400;

endmodule

/* rtl/date_difference_in_days.sv */
// ----------------------------------------------------------------------------
// date_difference_in_days
// Years in wrong order are answered from idle, in the cycle after the item.
// Otherwise earlier_year is first reduced modulo 400 by repeated subtraction,
// then the days are summed through the shared adder, one year a cycle when
// the years differ. One item at a time, busy is high meanwhile.
// Results are strobed for one cycle by done; the receiver cannot stall.
// Reset (rst_n low, asynchronous) returns the sequencer to idle, no done.
// ----------------------------------------------------------------------------
module date_difference_in_days (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ddd_pkg::request_t request,
    output logic              busy,
    output logic              done,
    output ddd_pkg::result_t  result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_OFFE,
        S_DAYE,
        S_YLEN,
        S_YEARS,
        S_OFFL,
        S_DAYL
    } state_t;

    state_t                            state_reg;
    logic                              done_reg;
    ddd_pkg::result_t                  result_reg;

    ddd_pkg::request_t                 req_reg;
    logic signed [ddd_pkg::ACC_W-1:0]  acc_reg;
    logic [ddd_pkg::YEAR_W-1:0]        r_reg;
    logic [ddd_pkg::YEAR_W-1:0]        yc_reg;

    logic                              accept;
    logic [ddd_pkg::YEAR_W-1:0]        r_next;
    logic [ddd_pkg::YEAR_W-1:0]        yc_next;
    logic                              last_year;
    logic                              leap_cur;
    logic                              leap_nxt;
    ddd_pkg::alu_op_t                  alu_op;
    logic signed [ddd_pkg::ACC_W-1:0]  alu_sum;
    logic signed [ddd_pkg::DIFF_W-1:0] sat_diff;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;

    assign r_next    = (r_reg == (ddd_pkg::YEAR_CYCLE - 14'd1)) ? '0 : (r_reg + 14'd1);
    assign yc_next   = yc_reg + 14'd1;
    assign last_year = (yc_next == req_reg.later_year);
    assign sat_diff  = (alu_sum > ddd_pkg::DIFF_MAX) ? ddd_pkg::DIFF_MAX[ddd_pkg::DIFF_W-1:0]
                                                     : alu_sum[ddd_pkg::DIFF_W-1:0];

    ddd_leap u_leap_cur (
        .r400 (r_reg[ddd_pkg::R400_W-1:0]),
        .leap (leap_cur)
    );

    ddd_leap u_leap_nxt (
        .r400 (r_next[ddd_pkg::R400_W-1:0]),
        .leap (leap_nxt)
    );

    ddd_alu u_alu (
        .op  (alu_op),
        .sum (alu_sum)
    );

    // operand select for the shared adder
    always_comb
    begin
        alu_op.sub = 1'b0;
        alu_op.a   = acc_reg;
        alu_op.b   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                alu_op.a = '0;
            end
            S_MOD:
            begin
                alu_op.sub = 1'b1;
                alu_op.a   = ddd_pkg::ACC_W'(r_reg);
                alu_op.b   = ddd_pkg::ACC_W'(ddd_pkg::YEAR_CYCLE);
            end
            S_OFFE:
            begin
                alu_op.sub = 1'b1;
                alu_op.a   = '0;
                alu_op.b   = ddd_pkg::ACC_W'(ddd_pkg::month_offset(req_reg.earlier_month,
                                                                 leap_cur));
            end
            S_DAYE:
            begin
                alu_op.sub = 1'b1;
                alu_op.b   = ddd_pkg::ACC_W'(req_reg.earlier_day);
            end
            S_YLEN:
            begin
                alu_op.b = ddd_pkg::year_len(leap_cur);
            end
            S_YEARS:
            begin
                alu_op.b = ddd_pkg::year_len(leap_nxt);
            end
            S_OFFL:
            begin
                alu_op.b = ddd_pkg::ACC_W'(ddd_pkg::month_offset(req_reg.later_month,
                                                               leap_cur));
            end
            S_DAYL:
            begin
                alu_op.b = ddd_pkg::ACC_W'(req_reg.later_day);
            end
        endcase
    end

    // sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (request.later_year < request.earlier_year)
                        begin
                            done_reg                  <= 1'b1;
                            result_reg.day_difference <= '0;
                            result_reg.order_error    <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_MOD;
                        end
                    end
                end
                S_MOD:
                begin
                    if (alu_sum[ddd_pkg::ACC_W-1])
                    begin
                        state_reg <= S_OFFE;
                    end
                end
                S_OFFE:
                begin
                    state_reg <= S_DAYE;
                end
                S_DAYE:
                begin
                    if (req_reg.later_year == req_reg.earlier_year)
                    begin
                        state_reg <= S_OFFL;
                    end
                    else
                    begin
                        state_reg <= S_YLEN;
                    end
                end
                S_YLEN:
                begin
                    state_reg <= S_YEARS;
                end
                S_YEARS:
                begin
                    if (last_year)
                    begin
                        state_reg <= S_OFFL;
                    end
                end
                S_OFFL:
                begin
                    state_reg <= S_DAYL;
                end
                S_DAYL:
                begin
                    done_reg                  <= 1'b1;
                    result_reg.day_difference <= sat_diff;
                    result_reg.order_error    <= 1'b0;
                    state_reg                 <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_reg <= request;
                    r_reg   <= request.earlier_year;
                    yc_reg  <= request.earlier_year;
                end
            end
            S_MOD:
            begin
                if (!alu_sum[ddd_pkg::ACC_W-1])
                begin
                    r_reg <= alu_sum[ddd_pkg::YEAR_W-1:0];
                end
            end
            S_YEARS:
            begin
                yc_reg <= yc_next;
                r_reg  <= r_next;
                if (!last_year)
                begin
                    acc_reg <= alu_sum;
                end
            end
            S_OFFE, S_DAYE, S_YLEN, S_OFFL, S_DAYL:
            begin
                acc_reg <= alu_sum;
            end
        endcase
    end

`ifndef SYNTH
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.order_error |-> result.day_difference == '0)
        else $error("order error item with nonzero difference");

    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("sequencer left busy without a result");

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted item neither started nor answered");

    a_r400: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_YEARS |-> r_reg < ddd_pkg::YEAR_CYCLE)
        else $error("year residue out of range during year walk");
`endif

endmodule

/* bench/date_difference_in_days_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// date_difference_in_days_test
// Drives date pairs into the block through the start/busy handshake and
// checks every strobed result against a day count worked out in the bench.
// A directed set covers leap rules, month and day extremes, wrong year order
// and saturation; random pairs follow, mostly valid dates a few years apart.
// ----------------------------------------------------------------------------
module date_difference_in_days_test;

    localparam int DIRECTED_ITEMS = 20;
    localparam int RANDOM_ITEMS   = 80;
    localparam int DRAIN_CYCLES   = 20;
    // widest span is 16383 years at one year a cycle
    localparam int CYCLE_LIMIT    = (DIRECTED_ITEMS + RANDOM_ITEMS) * 17000 * 4;

    class day_count_checker;
        ddd_pkg::result_t expected_counts[$];
        int               failures;

        function new();
            failures = 0;
        endfunction

        static function bit leap_year(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        static function int unsigned month_days(int unsigned m, bit leap);
            if (m == 2)
            begin
                return leap ? 29 : 28;
            end
            if (m == 4 || m == 6 || m == 9 || m == 11)
            begin
                return 30;
            end
            return 31;
        endfunction

        function longint day_of_year(int unsigned y, int unsigned m, int unsigned d);
            longint      sum;
            int unsigned last;
            sum  = 0;
            last = (m > 12) ? 12 : m;
            for (int unsigned k = 1; k < last; k++)
            begin
                sum += month_days(k, leap_year(y));
            end
            return sum + d;
        endfunction

        function ddd_pkg::result_t count_days(ddd_pkg::request_t q);
            ddd_pkg::result_t r;
            longint           diff;
            int unsigned      ly;
            int unsigned      ey;
            r  = '0;
            ly = q.later_year;
            ey = q.earlier_year;
            if (ly < ey)
            begin
                r.order_error = 1'b1;
                return r;
            end
            if (ly == ey)
            begin
                diff = day_of_year(ly, q.later_month, q.later_day)
                     - day_of_year(ey, q.earlier_month, q.earlier_day);
            end
            else
            begin
                diff = day_of_year(ly, q.later_month, q.later_day)
                     + (leap_year(ey) ? 366 : 365)
                     - day_of_year(ey, q.earlier_month, q.earlier_day);
                for (int unsigned y = ey + 1; y < ly; y++)
                begin
                    diff += leap_year(y) ? 366 : 365;
                end
            end
            if (diff > longint'(ddd_pkg::DIFF_MAX))
            begin
                diff = longint'(ddd_pkg::DIFF_MAX);
            end
            r.day_difference = diff[ddd_pkg::DIFF_W-1:0];
            return r;
        endfunction

        function void note_dates(ddd_pkg::request_t q);
            expected_counts.push_back(count_days(q));
        endfunction

        function void check_count(ddd_pkg::result_t got);
            ddd_pkg::result_t want;
            if (expected_counts.size() == 0)
            begin
                $error("unexpected result: day_difference %0d order_error %0d",
                       got.day_difference, got.order_error);
                failures++;
                return;
            end
            want = expected_counts.pop_front();
            if (got.day_difference !== want.day_difference)
            begin
                $error("day_difference: expected %0d, actual %0d",
                       want.day_difference, got.day_difference);
                failures++;
            end
            if (got.order_error !== want.order_error)
            begin
                $error("order_error: expected %0d, actual %0d",
                       want.order_error, got.order_error);
                failures++;
            end
        endfunction

        function int outstanding();
            return expected_counts.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    ddd_pkg::request_t request;
    logic              busy;
    logic              done;
    ddd_pkg::result_t  result;
    int                cycles = 0;

    day_count_checker counts;

    date_difference_in_days dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            counts.note_dates(request);
        end
        if (rst_n && done)
        begin
            counts.check_count(result);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic ddd_pkg::request_t dates(int unsigned ly, int unsigned lm,
                                                int unsigned ld, int unsigned ey,
                                                int unsigned em, int unsigned ed);
        ddd_pkg::request_t q;
        q.later_year    = ddd_pkg::YEAR_W'(ly);
        q.later_month   = ddd_pkg::MONTH_W'(lm);
        q.later_day     = ddd_pkg::DAY_W'(ld);
        q.earlier_year  = ddd_pkg::YEAR_W'(ey);
        q.earlier_month = ddd_pkg::MONTH_W'(em);
        q.earlier_day   = ddd_pkg::DAY_W'(ed);
        return q;
    endfunction

    function automatic int unsigned idle_gap();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
        begin
            return 0;
        end
        if (pick < 8)
        begin
            return $urandom_range(1, 3);
        end
        if (pick < 9)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic ddd_pkg::request_t random_dates();
        int unsigned kind;
        int unsigned ey;
        int unsigned ly;
        int unsigned lm;
        int unsigned em;
        kind = $urandom_range(0, 99);
        ey   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 9999);
        if (kind < 70)
        begin
            // valid dates a few years apart
            ly = ey + $urandom_range(0, 12);
            if (ly > 16383)
            begin
                ly = 16383;
            end
            lm = $urandom_range(1, 12);
            em = $urandom_range(1, 12);
            return dates(ly, lm,
                         $urandom_range(1, day_count_checker::month_days(lm,
                                        day_count_checker::leap_year(ly))),
                         ey, em,
                         $urandom_range(1, day_count_checker::month_days(em,
                                        day_count_checker::leap_year(ey))));
        end
        if (kind < 80)
        begin
            // years in wrong order
            if (ey == 0)
            begin
                ey = 1;
            end
            ly = $urandom_range(0, ey - 1);
        end
        else if (kind < 84)
        begin
            ly = $urandom_range(ey, 16383);
        end
        else
        begin
            ly = ey + $urandom_range(0, 3);
            if (ly > 16383)
            begin
                ly = 16383;
            end
        end
        return dates(ly, $urandom_range(0, 15), $urandom_range(0, 31),
                     ey, $urandom_range(0, 15), $urandom_range(0, 31));
    endfunction

    task automatic send_dates(input ddd_pkg::request_t q);
        int unsigned gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= q;
        do @(posedge clk); while (busy);
    endtask

    task automatic settle_counts();
        start <= 1'b0;
        do @(posedge clk); while (counts.outstanding() != 0);
    endtask

    initial
    begin
        counts  = new();
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_dates(dates(2000, 1, 1, 2000, 1, 1));
        send_dates(dates(2023, 1, 1, 2023, 12, 31));
        send_dates(dates(1999, 6, 15, 2000, 1, 1));
        send_dates(dates(2024, 3, 1, 2024, 2, 28));
        send_dates(dates(1900, 3, 1, 1900, 2, 28));
        send_dates(dates(2000, 3, 1, 2000, 2, 28));
        send_dates(dates(0, 3, 1, 0, 2, 28));
        send_dates(dates(2021, 0, 5, 2021, 1, 1));
        send_dates(dates(2021, 15, 31, 2021, 0, 0));
        send_dates(dates(2020, 2, 31, 2020, 2, 0));
        send_dates(dates(2023, 1, 1, 2022, 12, 31));
        send_dates(dates(2001, 0, 0, 2001, 15, 31));
        send_dates(dates(2000, 0, 0, 2000, 15, 31));
        send_dates(dates(0, 0, 0, 0, 0, 0));
        send_dates(dates(0, 12, 31, 16383, 1, 1));
        send_dates(dates(16383, 15, 31, 16383, 0, 0));
        send_dates(dates(12000, 7, 4, 11999, 12, 31));
        send_dates(dates(2100, 3, 1, 2096, 2, 29));
        send_dates(dates(9999, 12, 31, 0, 1, 1));
        send_dates(dates(16383, 12, 31, 0, 1, 1));
        settle_counts();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_dates(random_dates());
            if ($urandom_range(0, 19) == 0)
            begin
                settle_counts();
            end
        end
        settle_counts();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (counts.failures == 0 && counts.outstanding() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
